>>> rtl/qptq_pkg.sv
package qptq_pkg;

  localparam int HANDLE_W = 16;
  localparam int PRIO_W   = 8;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_PURGE  = 3'd1;
  localparam logic [2:0] OP_FLUSH  = 3'd2;
  localparam logic [2:0] OP_MARK   = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_EVICTED  = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_PURGED   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_DONE     = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;

  typedef struct packed {
    logic                busy;
    logic                drop;
    logic [PRIO_W-1:0]   prio;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [PRIO_W-1:0]   prio;
    logic                drop;
  } key_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_INSERT,
    CMD_REM_PURGE,
    CMD_REM_EVICT,
    CMD_REM_HEAD,
    CMD_FLUSH,
    CMD_MARK
  } cmd_t;

  // toward the tail
  typedef struct packed {
    entry_t              entry;
    logic                valid;
    logic                ins_cond;
    logic                hit_or;
    logic [HANDLE_W-1:0] vic_handle;
  } fwd_t;

  // toward the head
  typedef struct packed {
    entry_t entry;
    logic   valid;
    logic   cand_or;
  } bwd_t;

endpackage

>>> rtl/qptq_in_if.sv
interface qptq_in_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    op;
  logic [qptq_pkg::HANDLE_W-1:0] handle;
  logic [qptq_pkg::PRIO_W-1:0]   priority_req;
  logic                          droppable;

  modport source (output valid, op, handle, priority_req, droppable, input ready);
  modport sink   (input valid, op, handle, priority_req, droppable, output ready);
endinterface

>>> rtl/qptq_out_if.sv
interface qptq_out_if #(
  parameter int CNT_W = 5
);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [qptq_pkg::HANDLE_W-1:0] evicted_handle;
  logic [CNT_W-1:0]              entry_count;
  logic                          head_valid;
  logic [qptq_pkg::HANDLE_W-1:0] head_handle;
  logic                          head_busy;

  modport source (output valid, status, evicted_handle, entry_count, head_valid,
                  head_handle, head_busy, input ready);
  modport sink   (input valid, status, evicted_handle, entry_count, head_valid,
                  head_handle, head_busy, output ready);
endinterface

>>> rtl/qos_priority_tx_queue.sv
// channel  dir  handshake     payload
// in_ch    in   valid/ready   op, handle, priority_req, droppable
// out_ch   out  valid/ready   status, evicted_handle, entry_count, head_valid,
//                             head_handle, head_busy
// One item at a time: accept, one cell update, result load. An insert that
// evicts runs an evict pass, then an insert pass.
// Slot search and shifting run across the cell row in the update cycle.
// rst_n clears all cell valid bits and the fill count at once.
// A result waiting on out_ch does not block the next accept; a finished
// item waits for the output register before its result is loaded.
module qos_priority_tx_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int CNT_W = 5
) (
  input logic         clk,
  input logic         rst_n,
  qptq_in_if.sink     in_ch,
  qptq_out_if.source  out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_INS, S_DONE} state_t;

  state_t                        state_r;
  logic [2:0]                    op_r;
  qptq_pkg::key_t                key_r;
  logic [CNT_W-1:0]              fill_r;
  logic [2:0]                    status_r;
  logic [qptq_pkg::HANDLE_W-1:0] evicted_r;

  logic                          out_valid_r;
  logic [2:0]                    out_status_r;
  logic [qptq_pkg::HANDLE_W-1:0] out_evicted_r;
  logic [CNT_W-1:0]              out_count_r;
  logic                          out_head_valid_r;
  logic [qptq_pkg::HANDLE_W-1:0] out_head_handle_r;
  logic                          out_head_busy_r;

  qptq_pkg::cmd_t cmd;
  qptq_pkg::fwd_t fwd [0:QUEUE_DEPTH];
  qptq_pkg::bwd_t bwd [0:QUEUE_DEPTH];
  logic           full, empty;
  logic           load_out;

  assign fwd[0]           = '0;
  assign bwd[QUEUE_DEPTH] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    qptq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .key   (key_r),
      .fwd_i (fwd[i]),
      .bwd_i (bwd[i+1]),
      .fwd_o (fwd[i+1]),
      .bwd_o (bwd[i])
    );
  end

  assign full     = fill_r == CNT_W'(QUEUE_DEPTH);
  assign empty    = fill_r == '0;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    cmd = qptq_pkg::CMD_NOP;
    if (state_r == S_INS) begin
      cmd = qptq_pkg::CMD_INSERT;
    end else if (state_r == S_EXEC) begin
      case (op_r)
        qptq_pkg::OP_INSERT: begin
          if (!full) begin
            cmd = qptq_pkg::CMD_INSERT;
          end else if (bwd[0].cand_or) begin
            cmd = qptq_pkg::CMD_REM_EVICT;
          end
        end
        qptq_pkg::OP_PURGE: begin
          if (fwd[QUEUE_DEPTH].hit_or) begin
            cmd = qptq_pkg::CMD_REM_PURGE;
          end
        end
        qptq_pkg::OP_FLUSH: cmd = qptq_pkg::CMD_FLUSH;
        qptq_pkg::OP_MARK: begin
          if (!empty) begin
            cmd = qptq_pkg::CMD_MARK;
          end
        end
        qptq_pkg::OP_REMOVE: begin
          if (!empty) begin
            cmd = qptq_pkg::CMD_REM_HEAD;
          end
        end
        default: cmd = qptq_pkg::CMD_NOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r         <= in_ch.op;
            key_r.handle <= in_ch.handle;
            key_r.prio   <= in_ch.priority_req;
            key_r.drop   <= in_ch.droppable;
            state_r      <= S_EXEC;
          end
        end
        S_EXEC: begin
          evicted_r <= '0;
          status_r  <= qptq_pkg::ST_DONE;
          state_r   <= S_DONE;
          case (op_r)
            qptq_pkg::OP_INSERT: begin
              if (!full) begin
                status_r <= qptq_pkg::ST_INSERTED;
                fill_r   <= fill_r + CNT_W'(1);
              end else if (bwd[0].cand_or) begin
                status_r  <= qptq_pkg::ST_EVICTED;
                evicted_r <= fwd[QUEUE_DEPTH].vic_handle;
                state_r   <= S_INS;
              end else begin
                status_r <= qptq_pkg::ST_REJECTED;
              end
            end
            qptq_pkg::OP_PURGE: begin
              if (fwd[QUEUE_DEPTH].hit_or) begin
                status_r <= qptq_pkg::ST_PURGED;
                fill_r   <= fill_r - CNT_W'(1);
              end else begin
                status_r <= qptq_pkg::ST_NOTFOUND;
              end
            end
            qptq_pkg::OP_FLUSH: fill_r <= '0;
            qptq_pkg::OP_MARK: begin
              if (empty) begin
                status_r <= qptq_pkg::ST_EMPTY;
              end
            end
            qptq_pkg::OP_REMOVE: begin
              if (empty) begin
                status_r <= qptq_pkg::ST_EMPTY;
              end else begin
                fill_r <= fill_r - CNT_W'(1);
              end
            end
            default: status_r <= qptq_pkg::ST_DONE;
          endcase
        end
        // eviction pass left the count unchanged net of this insert
        S_INS: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            out_status_r      <= status_r;
            out_evicted_r     <= evicted_r;
            out_count_r       <= fill_r;
            out_head_valid_r  <= bwd[0].valid;
            out_head_handle_r <= bwd[0].valid ? bwd[0].entry.handle : '0;
            out_head_busy_r   <= bwd[0].valid & bwd[0].entry.busy;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready           = state_r == S_IDLE;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.evicted_handle = out_evicted_r;
  assign out_ch.entry_count    = out_count_r;
  assign out_ch.head_valid     = out_head_valid_r;
  assign out_ch.head_handle    = out_head_handle_r;
  assign out_ch.head_busy      = out_head_busy_r;

endmodule

>>> rtl/qptq_cell.sv
module qptq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  qptq_pkg::cmd_t    cmd,
  input  qptq_pkg::key_t    key,
  input  qptq_pkg::fwd_t    fwd_i,
  input  qptq_pkg::bwd_t    bwd_i,
  output qptq_pkg::fwd_t    fwd_o,
  output qptq_pkg::bwd_t    bwd_o
);

  qptq_pkg::entry_t entry_r, entry_nxt;
  logic             valid_r, valid_nxt;
  qptq_pkg::entry_t new_entry;
  logic             lower, cond, match, cand, victim;

  always_comb begin
    lower  = entry_r.prio < key.prio;
    cond   = !valid_r || (lower && !entry_r.busy);
    match  = valid_r && (entry_r.handle == key.handle);
    cand   = valid_r && entry_r.drop && !entry_r.busy && lower;
    victim = cand && !bwd_i.cand_or;

    new_entry.busy   = 1'b0;
    new_entry.drop   = key.drop;
    new_entry.prio   = key.prio;
    new_entry.handle = key.handle;

    fwd_o.entry      = entry_r;
    fwd_o.valid      = valid_r;
    fwd_o.ins_cond   = cond;
    fwd_o.hit_or     = fwd_i.hit_or | match;
    fwd_o.vic_handle = fwd_i.vic_handle | (victim ? entry_r.handle : '0);

    bwd_o.entry   = entry_r;
    bwd_o.valid   = valid_r;
    bwd_o.cand_or = cand | bwd_i.cand_or;
  end

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    case (cmd)
      qptq_pkg::CMD_INSERT: begin
        if (fwd_i.ins_cond) begin
          entry_nxt = fwd_i.entry;
          valid_nxt = fwd_i.valid;
        end else if (cond) begin
          entry_nxt = new_entry;
          valid_nxt = 1'b1;
        end
      end
      qptq_pkg::CMD_REM_PURGE: begin
        if (fwd_i.hit_or | match) begin
          entry_nxt = bwd_i.entry;
          valid_nxt = bwd_i.valid;
        end
      end
      qptq_pkg::CMD_REM_EVICT: begin
        if (!bwd_i.cand_or) begin
          entry_nxt = bwd_i.entry;
          valid_nxt = bwd_i.valid;
        end
      end
      qptq_pkg::CMD_REM_HEAD: begin
        entry_nxt = bwd_i.entry;
        valid_nxt = bwd_i.valid;
      end
      qptq_pkg::CMD_FLUSH: begin
        valid_nxt = 1'b0;
      end
      qptq_pkg::CMD_MARK: begin
        if (valid_r && !fwd_i.valid) begin
          entry_nxt.busy = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

>>> bench/tb_qos_priority_tx_queue.sv
module tb_qos_priority_tx_queue;

  localparam int QDEPTH      = 16;
  localparam int N_RANDOM    = 1750;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_STEP   = 600;
  localparam int DRAIN_WAIT  = 20;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]                    op;
    logic [qptq_pkg::HANDLE_W-1:0] handle;
    logic [qptq_pkg::PRIO_W-1:0]   prio;
    logic                          drop;
  } qop_t;

  typedef struct packed {
    logic [2:0]                    status;
    logic [qptq_pkg::HANDLE_W-1:0] evicted;
    logic [4:0]                    count;
    logic                          head_valid;
    logic [qptq_pkg::HANDLE_W-1:0] head_handle;
    logic                          head_busy;
  } qres_t;

  logic clk = 1'b0;
  logic rst_n;

  qptq_in_if               in_ch ();
  qptq_out_if #(.CNT_W(5)) out_ch ();

  qos_priority_tx_queue #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // queue shadow
  qptq_pkg::entry_t slot_model[QDEPTH];
  int               fill_model = 0;

  qop_t          pending_ops[$];
  qres_t         predicted_results[$];
  logic [15:0]   recent_handles[$];
  qop_t          cur_op;

  int n_stim       = 0;
  int accepted_cnt = 0;
  int results_seen = 0;
  int err_cnt      = 0;
  int evict_seen   = 0;
  int reject_seen  = 0;
  int purge_seen   = 0;
  int full_seen    = 0;
  int cycle_cnt    = 0;
  int tx_wait      = 0;
  int rx_wait      = 0;
  int hold_left    = 0;
  int holds_done   = 0;
  bit tx_burst     = 1'b0;
  bit rx_burst     = 1'b0;
  logic rx_hold;

  function automatic void drop_slot(int pos);
    for (int i = pos; i < fill_model - 1; i++) slot_model[i] = slot_model[i + 1];
    fill_model--;
  endfunction

  function automatic qres_t queue_apply(qop_t r);
    qres_t            res;
    qptq_pkg::entry_t ent;
    int               victim;
    int               pos;
    bit               placed;
    res = '0;
    res.status = qptq_pkg::ST_DONE;
    victim = -1;
    case (r.op)
      qptq_pkg::OP_INSERT: begin
        placed = 1'b1;
        res.status = qptq_pkg::ST_INSERTED;
        if (fill_model == QDEPTH) begin
          for (int i = 0; i < fill_model; i++)
            if (slot_model[i].drop && !slot_model[i].busy && slot_model[i].prio < r.prio)
              victim = i;
          if (victim >= 0) begin
            res.status = qptq_pkg::ST_EVICTED;
            res.evicted = slot_model[victim].handle;
            drop_slot(victim);
          end else begin
            res.status = qptq_pkg::ST_REJECTED;
            placed = 1'b0;
          end
        end
        if (placed) begin
          pos = fill_model;
          // busy head is never passed
          for (int i = fill_model - 1; i >= 0; i--)
            if (!(i == 0 && slot_model[0].busy) && slot_model[i].prio < r.prio) pos = i;
          for (int i = fill_model; i > pos; i--) slot_model[i] = slot_model[i - 1];
          ent.busy   = 1'b0;
          ent.drop   = r.drop;
          ent.prio   = r.prio;
          ent.handle = r.handle;
          slot_model[pos] = ent;
          fill_model++;
        end
      end
      qptq_pkg::OP_PURGE: begin
        for (int i = fill_model - 1; i >= 0; i--)
          if (slot_model[i].handle == r.handle) victim = i;
        if (victim >= 0) begin
          res.status = qptq_pkg::ST_PURGED;
          drop_slot(victim);
        end else begin
          res.status = qptq_pkg::ST_NOTFOUND;
        end
      end
      qptq_pkg::OP_FLUSH: fill_model = 0;
      qptq_pkg::OP_MARK: begin
        if (fill_model == 0) res.status = qptq_pkg::ST_EMPTY;
        else slot_model[0].busy = 1'b1;
      end
      qptq_pkg::OP_REMOVE: begin
        if (fill_model == 0) res.status = qptq_pkg::ST_EMPTY;
        else drop_slot(0);
      end
      default: ;
    endcase
    res.count = 5'(fill_model);
    if (fill_model > 0) begin
      res.head_valid  = 1'b1;
      res.head_handle = slot_model[0].handle;
      res.head_busy   = slot_model[0].busy;
    end
    return res;
  endfunction

  function automatic void queue_op(logic [2:0] op, logic [15:0] h, logic [7:0] p, logic d);
    qop_t it;
    it.op     = op;
    it.handle = h;
    it.prio   = p;
    it.drop   = d;
    pending_ops.push_back(it);
  endfunction

  // kind 0 fills, 1 mixes, 2 drains
  function automatic qop_t gen_item(int kind);
    qop_t it;
    int   roll;
    int   ins_pct;
    int   pur_pct;
    int   mark_pct;
    int   rem_pct;
    roll = $urandom_range(0, 99);
    ins_pct  = (kind == 0) ? 74 : (kind == 1) ? 44 : 18;
    pur_pct  = (kind == 0) ? 8  : (kind == 1) ? 16 : 15;
    mark_pct = (kind == 0) ? 8  : (kind == 1) ? 16 : 20;
    rem_pct  = (kind == 0) ? 8  : (kind == 1) ? 22 : 45;
    it.handle = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
    it.prio   = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3) * 85) : 8'($urandom);
    it.drop   = 1'($urandom);
    if (roll < ins_pct) begin
      it.op = qptq_pkg::OP_INSERT;
      recent_handles.push_back(it.handle);
      if (recent_handles.size() > 24) void'(recent_handles.pop_front());
    end else if (roll < ins_pct + pur_pct) begin
      it.op = qptq_pkg::OP_PURGE;
      if (recent_handles.size() > 0 && $urandom_range(0, 9) < 7)
        it.handle = recent_handles[$urandom_range(0, recent_handles.size() - 1)];
    end else if (roll < ins_pct + pur_pct + mark_pct) begin
      it.op = qptq_pkg::OP_MARK;
    end else if (roll < ins_pct + pur_pct + mark_pct + rem_pct) begin
      it.op = qptq_pkg::OP_REMOVE;
    end else if ($urandom_range(0, 3) == 0) begin
      // unused codes above remove
      it.op = qptq_pkg::OP_REMOVE + 3'($urandom_range(1, 3));
    end else begin
      it.op = qptq_pkg::OP_FLUSH;
    end
    return it;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predicted_results.push_back(queue_apply(cur_op));
        accepted_cnt <= accepted_cnt + 1;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        tx_wait = (tx_burst || rx_hold) ? 0 : $urandom_range(0, 18);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_ch.valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          cur_op = pending_ops.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.op           <= cur_op.op;
          in_ch.handle       <= cur_op.handle;
          in_ch.priority_req <= cur_op.prio;
          in_ch.droppable    <= cur_op.drop;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    qres_t got;
    qres_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.status, out_ch.evicted_handle, out_ch.entry_count, out_ch.head_valid,
               out_ch.head_handle, out_ch.head_busy};
        results_seen++;
        if (got.status == qptq_pkg::ST_EVICTED) evict_seen++;
        if (got.status == qptq_pkg::ST_REJECTED) reject_seen++;
        if (got.status == qptq_pkg::ST_PURGED) purge_seen++;
        if (got.count == 5'(QDEPTH)) full_seen++;
        if (predicted_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("result %0d arrived with nothing outstanding: st=%0d cnt=%0d",
                     results_seen, got.status, got.count);
        end else begin
          want = predicted_results.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("result %0d: exp st=%0d ev=%h cnt=%0d hv=%b hh=%h hb=%b",
                       results_seen, want.status, want.evicted, want.count,
                       want.head_valid, want.head_handle, want.head_busy);
              $display("result %0d: got st=%0d ev=%h cnt=%0d hv=%b hh=%h hb=%b",
                       results_seen, got.status, got.evicted, got.count,
                       got.head_valid, got.head_handle, got.head_busy);
            end
          end
        end
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 18);
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !rx_hold;
      end
    end
  end

  // long receiver hold-off so the input backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold <= 1'b0;
      hold_left = 0;
    end else begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (holds_done < 2 && accepted_cnt >= (holds_done + 1) * HOLD_STEP) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      rx_hold <= (hold_left > 0);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("qos_priority_tx_queue test failed");
      $finish;
    end
  end

  initial begin
    int kind;
    int run_len;
    qop_t it;
    rst_n <= 1'b0;

    // empty queue corners
    queue_op(qptq_pkg::OP_REMOVE, 16'h0000, 8'd0, 1'b0);
    queue_op(qptq_pkg::OP_MARK,   16'h0000, 8'd0, 1'b0);
    queue_op(qptq_pkg::OP_PURGE,  16'hFFFF, 8'd0, 1'b0);
    queue_op(qptq_pkg::OP_INSERT, 16'h0000, 8'd0, 1'b0);
    queue_op(qptq_pkg::OP_INSERT, 16'hFFFF, 8'd255, 1'b1);
    queue_op(qptq_pkg::OP_MARK,   16'h0000, 8'd0, 1'b0);
    // an equal-priority insert must stay behind the busy head
    queue_op(qptq_pkg::OP_INSERT, 16'h5555, 8'd255, 1'b1);
    queue_op(qptq_pkg::OP_PURGE,  16'hFFFF, 8'd0, 1'b0);
    queue_op(qptq_pkg::OP_FLUSH,  16'h0000, 8'd0, 1'b0);
    for (int i = 0; i < QDEPTH; i++)
      queue_op(qptq_pkg::OP_INSERT, 16'h0100 + 16'(i), 8'(i * 17), 1'(i));
    // full: no lower droppable entry, then an eviction
    queue_op(qptq_pkg::OP_INSERT, 16'hAAAA, 8'd0, 1'b1);
    queue_op(qptq_pkg::OP_INSERT, 16'hBEEF, 8'd255, 1'b1);

    while (pending_ops.size() < N_RANDOM + 25) begin
      kind = $urandom_range(0, 2);
      run_len = $urandom_range(20, 60);
      for (int j = 0; j < run_len; j++) begin
        it = gen_item(kind);
        pending_ops.push_back(it);
      end
    end
    n_stim = pending_ops.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < n_stim || predicted_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d operations driven, %0d results checked, %0d mismatches",
             n_stim, results_seen, err_cnt);
    $display("%0d evictions, %0d full rejects, %0d purge hits, %0d results at full depth",
             evict_seen, reject_seen, purge_seen, full_seen);
    if (err_cnt == 0 && predicted_results.size() == 0) begin
      $display("qos_priority_tx_queue test passed");
    end else begin
      $display("qos_priority_tx_queue test failed");
    end
    $finish;
  end

endmodule
